/* sv/dsd_pkg.sv */
`timescale 1ns / 1ps

package dsd_pkg;

  // Queue and group dimensions.
  localparam int QUEUE_DEPTH = 8;
  localparam int GROUP_COUNT = 8;
  localparam int MAX_RESULTS = 64;

  // Field widths.
  localparam int REQ_W      = 2;
  localparam int CODE_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int SENDER_W   = 8;
  localparam int GROUP_W    = 3;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Derived counter widths.
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_code_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTERED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLER    = 2'd2;

  // Result kinds.
  localparam logic KIND_DELIVERY = 1'b0;
  localparam logic KIND_REJECT   = 1'b1;

  // One pending signal in the queue.
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [DELAY_W-1:0]  delay;
    logic [SENDER_W-1:0] sender;
    logic [GROUP_W-1:0]  target;
    logic                bcast;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic latch_code;
    logic clear;
    logic tick_start;
    logic scan_keep;
    logic scan_next;
    logic grp_start;
    logic grp_step;
    logic commit;
    logic flush;
    logic load_reject;
  } dsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic scan_done;
    logic expired;
    logic grp_last;
    logic can_step;
    logic hold_valid;
    logic out_free;
  } dsd_status_t;

endpackage

/* sv/dsd_if.sv */
`timescale 1ns / 1ps

// Request channel into the dispatcher.
interface dsd_req_if;
  logic                          valid;
  logic                          ready;
  logic [dsd_pkg::REQ_W-1:0]     req_type;
  logic [dsd_pkg::CODE_W-1:0]    signal_code;
  logic [dsd_pkg::DELAY_W-1:0]   delay_ticks;
  logic [dsd_pkg::SENDER_W-1:0]  sender_id;
  logic [dsd_pkg::GROUP_W-1:0]   receiver_group;
  logic                          broadcast;

  modport source (output valid, req_type, signal_code, delay_ticks, sender_id,
                  receiver_group, broadcast, input ready);
  modport sink (input valid, req_type, signal_code, delay_ticks, sender_id,
                receiver_group, broadcast, output ready);
endinterface

// Result channel out of the dispatcher.
interface dsd_res_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [dsd_pkg::CODE_W-1:0]    out_signal;
  logic [dsd_pkg::SENDER_W-1:0]  out_sender;
  logic [dsd_pkg::GROUP_W-1:0]   target_group;
  logic                          last;

  modport source (output valid, kind, out_signal, out_sender, target_group, last,
                  input ready);
  modport sink (input valid, kind, out_signal, out_sender, target_group, last,
                output ready);
endinterface

// Configuration write channel.
interface dsd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dsd_pkg::CFG_IDX_W-1:0]   index;
  logic [dsd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/dsd_datapath.sv */
`timescale 1ns / 1ps

module dsd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dsd_pkg::dsd_cmd_t             cmd,
  output dsd_pkg::dsd_status_t          status,
  input  logic [dsd_pkg::CODE_W-1:0]    signal_code,
  input  logic [dsd_pkg::DELAY_W-1:0]   delay_ticks,
  input  logic [dsd_pkg::SENDER_W-1:0]  sender_id,
  input  logic [dsd_pkg::GROUP_W-1:0]   receiver_group,
  input  logic                          broadcast,
  dsd_cfg_if.sink                       cfg,
  dsd_res_if.source                     res
);
  import dsd_pkg::*;

  entry_t queue [QUEUE_DEPTH];
  entry_t cur;
  entry_t kept_entry;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    kept;
  logic [GROUP_W-1:0]  grp;
  logic [RES_W-1:0]    res_cnt;
  logic [MASK_W-1:0]   registered_mask;
  logic [MASK_W-1:0]   muted_mask;
  logic [MASK_W-1:0]   handler_mask;
  logic [MASK_W-1:0]   eligible;
  logic [CODE_W-1:0]   rej_code;

  logic                hold_valid;
  logic [CODE_W-1:0]   hold_code;
  logic [SENDER_W-1:0] hold_sender;
  logic [GROUP_W-1:0]  hold_group;

  logic                out_valid;
  logic                out_kind;
  logic [CODE_W-1:0]   out_code;
  logic [SENDER_W-1:0] out_sender;
  logic [GROUP_W-1:0]  out_group;
  logic                out_last;

  logic                hit;
  logic                out_free;
  logic                load_out;

  // Entry under the scan pointer, and its copy with the delay counted down.
  assign cur = queue[idx[IDX_W-1:0]];
  always_comb begin
    kept_entry       = cur;
    kept_entry.delay = cur.delay - 1'b1;
  end

  // A group takes the current entry when eligible and addressed, up to the result limit of a tick.
  assign eligible = registered_mask & ~muted_mask & handler_mask;
  assign hit      = eligible[grp] && (cur.bcast || (cur.target == grp)) &&
                    (res_cnt < RES_W'(MAX_RESULTS));
  assign out_free = !out_valid || res.ready;
  assign load_out = cmd.load_reject || cmd.flush ||
                    (cmd.grp_step && hit && hold_valid);

  // Status back to the controller.
  always_comb begin
    status.full       = (count == CNT_W'(QUEUE_DEPTH));
    status.scan_done  = (idx == count);
    status.expired    = (cur.delay == '0);
    status.grp_last   = (grp == GROUP_W'(GROUP_COUNT - 1));
    status.can_step   = !hit || !hold_valid || out_free;
    status.hold_valid = hold_valid;
    status.out_free   = out_free;
  end

  // Queue storage: appends at the tail, compaction writes behind the scan.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      queue[count[IDX_W-1:0]] <= '{code: signal_code, delay: delay_ticks,
                                   sender: sender_id, target: receiver_group,
                                   bcast: broadcast};
    end else if (cmd.scan_keep) begin
      queue[kept[IDX_W-1:0]] <= kept_entry;
    end
  end

  // Counters, masks and valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      idx             <= '0;
      kept            <= '0;
      grp             <= '0;
      res_cnt         <= '0;
      hold_valid      <= 1'b0;
      out_valid       <= 1'b0;
      registered_mask <= '0;
      muted_mask      <= '0;
      handler_mask    <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_REGISTERED: registered_mask <= cfg.data;
          CFG_MUTED:      muted_mask      <= cfg.data;
          CFG_HANDLER:    handler_mask    <= cfg.data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= count + 1'b1;
      end else if (cmd.commit) begin
        count <= kept;
      end
      if (cmd.tick_start) begin
        idx        <= '0;
        kept       <= '0;
        res_cnt    <= '0;
        hold_valid <= 1'b0;
      end
      if (cmd.scan_keep) begin
        kept <= kept + 1'b1;
        idx  <= idx + 1'b1;
      end else if (cmd.scan_next) begin
        idx <= idx + 1'b1;
      end
      if (cmd.grp_start) begin
        grp <= '0;
      end else if (cmd.grp_step) begin
        grp <= grp + 1'b1;
        if (hit) begin
          res_cnt    <= res_cnt + 1'b1;
          hold_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      out_valid <= (out_valid && !res.ready) || load_out;
    end
  end

  // Held delivery, output register and rejected code.
  always_ff @(posedge clk) begin
    if (cmd.latch_code) begin
      rej_code <= signal_code;
    end
    if (load_out) begin
      if (cmd.load_reject) begin
        out_kind   <= KIND_REJECT;
        out_code   <= rej_code;
        out_sender <= '0;
        out_group  <= '0;
        out_last   <= 1'b1;
      end else begin
        out_kind   <= KIND_DELIVERY;
        out_code   <= hold_code;
        out_sender <= hold_sender;
        out_group  <= hold_group;
        out_last   <= cmd.flush;
      end
    end
    if (cmd.grp_step && hit) begin
      hold_code   <= cur.code;
      hold_sender <= cur.sender;
      hold_group  <= grp;
    end
  end

  assign cfg.ready        = 1'b1;
  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.out_signal   = out_code;
  assign res.out_sender   = out_sender;
  assign res.target_group = out_group;
  assign res.last         = out_last;

  // Compaction never overtakes the scan.
  a_kept_behind: assert property (@(posedge clk) disable iff (rst) kept <= idx)
    else $error("compaction pointer ahead of scan pointer");

  // The fill count never exceeds the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output register overwritten");

  // A reject always closes its request.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_REJECT) |-> out_last)
    else $error("reject result without last");

  // Results per tick stay within the limit.
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_W'(MAX_RESULTS))
    else $error("too many results in one tick");

endmodule

/* sv/dsd_ctrl.sv */
`timescale 1ns / 1ps

module dsd_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [dsd_pkg::REQ_W-1:0] req_type,
  output logic                      req_ready,
  input  dsd_pkg::dsd_status_t      status,
  output dsd_pkg::dsd_cmd_t         cmd
);
  import dsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REJECT,
    S_SCAN,
    S_FAN,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Sequencing of requests and of the tick walk.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_ADD: begin
              if (status.full) begin
                cmd.latch_code = 1'b1;
                state_next     = S_REJECT;
              end else begin
                cmd.append = 1'b1;
              end
            end
            REQ_TICK: begin
              cmd.tick_start = 1'b1;
              state_next     = S_SCAN;
            end
            REQ_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_REJECT: begin
        if (status.out_free) begin
          cmd.load_reject = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          cmd.commit = 1'b1;
          state_next = S_FLUSH;
        end else if (status.expired) begin
          cmd.grp_start = 1'b1;
          state_next    = S_FAN;
        end else begin
          cmd.scan_keep = 1'b1;
        end
      end
      S_FAN: begin
        if (status.can_step) begin
          cmd.grp_step = 1'b1;
          if (status.grp_last) begin
            cmd.scan_next = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (!status.hold_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/delayed_signal_dispatcher_core.sv */
`timescale 1ns / 1ps

// Channel  Role    Moves
// req      sink    one request: add, tick or clear, with the signal fields
// res      source  one result: delivery or reject, last marks the end
// cfg      sink    one register write: index 0 registered, 1 muted, 2 handler
//
// A rejected add passes through the reject state and loads its result once the
// output register is free. In a tick the controller walks the queue entry by entry
// and, for each expired entry, walks the groups.
// Each delivery is held until another replaces it, so that the last of a tick can be marked.
// A stalled result channel holds the walk at the next delivery; reset empties the queue.
module delayed_signal_dispatcher_core (
  input  logic      clk,
  input  logic      rst,
  dsd_req_if.sink   req,
  dsd_res_if.source res,
  dsd_cfg_if.sink   cfg
);
  import dsd_pkg::*;

  dsd_cmd_t    cmd;
  dsd_status_t status;
  logic        req_ready;

  assign req.ready = req_ready;

  dsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dsd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .signal_code    (req.signal_code),
    .delay_ticks    (req.delay_ticks),
    .sender_id      (req.sender_id),
    .receiver_group (req.receiver_group),
    .broadcast      (req.broadcast),
    .cfg            (cfg),
    .res            (res)
  );

endmodule

/* tb/dispatch_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the dispatcher.
// It keeps its own copy of the pending queue and the group masks, works out the
// results that each accepted request should cause, and compares each result
// that comes out against the oldest one still awaited.
module dispatch_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic                              req_ready,
  input  logic [dsd_pkg::REQ_W-1:0]         req_type,
  input  logic [dsd_pkg::CODE_W-1:0]        signal_code,
  input  logic [dsd_pkg::DELAY_W-1:0]       delay_ticks,
  input  logic [dsd_pkg::SENDER_W-1:0]      sender_id,
  input  logic [dsd_pkg::GROUP_W-1:0]       receiver_group,
  input  logic                              broadcast,
  input  logic                              res_valid,
  input  logic                              res_ready,
  input  logic                              res_kind,
  input  logic [dsd_pkg::CODE_W-1:0]        res_signal,
  input  logic [dsd_pkg::SENDER_W-1:0]      res_sender,
  input  logic [dsd_pkg::GROUP_W-1:0]       res_group,
  input  logic                              res_last,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [dsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              drained,
  output int                                fail_count,
  output int                                outstanding
);
  import dsd_pkg::*;

  // One result as the dispatcher should present it.
  typedef struct packed {
    logic                kind;
    logic [CODE_W-1:0]   code;
    logic [SENDER_W-1:0] sender;
    logic [GROUP_W-1:0]  grp;
    logic                last;
  } outcome_t;

  outcome_t          awaited_outcomes[$];
  outcome_t          oldest;
  entry_t            pending[QUEUE_DEPTH];
  int unsigned       pending_used;
  logic [MASK_W-1:0] registered_bits;
  logic [MASK_W-1:0] muted_bits;
  logic [MASK_W-1:0] handler_bits;
  bit                leftovers_checked;

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] dispatcher mismatch: %s got 0x%0h, expected 0x%0h",
             $time, what, got, want);
    fail_count++;
  endtask

  // Applies one accepted request to the local queue and records the results due.
  task automatic predict_request(input logic [REQ_W-1:0] op,
                                 input logic [CODE_W-1:0] code,
                                 input logic [DELAY_W-1:0] delay,
                                 input logic [SENDER_W-1:0] sender,
                                 input logic [GROUP_W-1:0] grp,
                                 input logic bc);
    outcome_t          item;
    logic [MASK_W-1:0] eligible;
    int unsigned       kept;
    int                produced;
    case (op)
      REQ_ADD: begin
        if (pending_used >= QUEUE_DEPTH) begin
          item = '{KIND_REJECT, code, '0, '0, 1'b1};
          awaited_outcomes = {awaited_outcomes, item};
        end else begin
          pending[pending_used] = '{code, delay, sender, grp, bc};
          pending_used++;
        end
      end
      REQ_CLEAR: begin
        pending_used = 0;
      end
      REQ_TICK: begin
        eligible = registered_bits & ~muted_bits & handler_bits;
        kept     = 0;
        produced = 0;
        // Walk the queue in order: waiting entries count down and close up,
        // expired ones fan out over the eligible groups.
        for (int i = 0; i < pending_used; i++) begin
          if (pending[i].delay != '0) begin
            pending[kept]       = pending[i];
            pending[kept].delay = pending[i].delay - 1'b1;
            kept++;
          end else begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
              if (eligible[g] && (pending[i].bcast || pending[i].target == g) &&
                  produced < MAX_RESULTS) begin
                item = '{KIND_DELIVERY, pending[i].code, pending[i].sender,
                         GROUP_W'(g), 1'b0};
                awaited_outcomes = {awaited_outcomes, item};
                produced++;
              end
            end
          end
        end
        pending_used = kept;
        // The final delivery of the tick carries the last mark.
        if (produced > 0) begin
          item      = awaited_outcomes[awaited_outcomes.size() - 1];
          item.last = 1'b1;
          awaited_outcomes[awaited_outcomes.size() - 1] = item;
        end
      end
      default: begin
        // The spare request code leaves everything as it was.
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited_outcomes.delete();
      pending_used      = 0;
      registered_bits   = '0;
      muted_bits        = '0;
      handler_bits      = '0;
      fail_count        = 0;
      leftovers_checked = 1'b0;
    end else begin
      // Results are compared before the new request is predicted, since a
      // result can never belong to a request accepted at the same edge.
      if (res_valid && res_ready) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("result with nothing awaited, signal", 32'(res_signal), '0);
        end else begin
          oldest = awaited_outcomes.pop_front();
          if (res_kind !== oldest.kind)
            report_mismatch("kind", 32'(res_kind), 32'(oldest.kind));
          if (res_signal !== oldest.code)
            report_mismatch("out_signal", 32'(res_signal), 32'(oldest.code));
          if (res_sender !== oldest.sender)
            report_mismatch("out_sender", 32'(res_sender), 32'(oldest.sender));
          if (res_group !== oldest.grp)
            report_mismatch("target_group", 32'(res_group), 32'(oldest.grp));
          if (res_last !== oldest.last)
            report_mismatch("last", 32'(res_last), 32'(oldest.last));
        end
      end

      // Register writes; the spare index changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REGISTERED: registered_bits = cfg_data;
          CFG_MUTED:      muted_bits      = cfg_data;
          CFG_HANDLER:    handler_bits    = cfg_data;
          default: begin
          end
        endcase
      end

      if (req_valid && req_ready)
        predict_request(req_type, signal_code, delay_ticks, sender_id,
                        receiver_group, broadcast);

      // Anything still awaited once the run has drained never arrived.
      if (drained && !leftovers_checked) begin
        if (awaited_outcomes.size() != 0)
          report_mismatch("results never delivered", '0,
                          32'(awaited_outcomes.size()));
        leftovers_checked = 1'b1;
      end
    end
    outstanding <= awaited_outcomes.size();
  end

endmodule

/* tb/delayed_signal_dispatcher_core_tb.sv */
`timescale 1ns / 1ps

module delayed_signal_dispatcher_core_tb;
  import dsd_pkg::*;

  // Codes that the block has no meaning for.
  localparam logic [REQ_W-1:0]     REQ_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 100;
  localparam int PHASE_ITEMS     = 18;
  localparam int PHASE_COUNT     = 6;

  logic clk = 1'b0;
  logic rst;
  logic drained;
  int   fail_count;
  int   outstanding;
  bit   hold_off_req;
  bit   quiet_tail;

  always #5 clk = ~clk;

  dsd_req_if req_bus ();
  dsd_res_if res_bus ();
  dsd_cfg_if cfg_bus ();

  delayed_signal_dispatcher_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  dispatch_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_bus.valid),
    .req_ready      (req_bus.ready),
    .req_type       (req_bus.req_type),
    .signal_code    (req_bus.signal_code),
    .delay_ticks    (req_bus.delay_ticks),
    .sender_id      (req_bus.sender_id),
    .receiver_group (req_bus.receiver_group),
    .broadcast      (req_bus.broadcast),
    .res_valid      (res_bus.valid),
    .res_ready      (res_bus.ready),
    .res_kind       (res_bus.kind),
    .res_signal     (res_bus.out_signal),
    .res_sender     (res_bus.out_sender),
    .res_group      (res_bus.target_group),
    .res_last       (res_bus.last),
    .cfg_valid      (cfg_bus.valid),
    .cfg_ready      (cfg_bus.ready),
    .cfg_index      (cfg_bus.index),
    .cfg_data       (cfg_bus.data),
    .drained        (drained),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // Offers one request and waits until it is taken, then perhaps idles.
  task automatic offer(input logic [REQ_W-1:0] op, input logic [CODE_W-1:0] code,
                       input logic [DELAY_W-1:0] delay,
                       input logic [SENDER_W-1:0] sender,
                       input logic [GROUP_W-1:0] grp, input logic bc);
    req_bus.valid          <= 1'b1;
    req_bus.req_type       <= op;
    req_bus.signal_code    <= code;
    req_bus.delay_ticks    <= delay;
    req_bus.sender_id      <= sender;
    req_bus.receiver_group <= grp;
    req_bus.broadcast      <= bc;
    do @(posedge clk); while (!req_bus.ready);
    if (!quiet_tail && $urandom_range(0, 2) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Half adds, the rest ticks, clears and spare codes; short delays mostly, now and then one across the full range.
  task automatic random_request();
    int                  pick;
    logic [REQ_W-1:0]    op;
    logic [DELAY_W-1:0]  delay;
    pick = $urandom_range(0, 99);
    if (pick < 50)      op = REQ_ADD;
    else if (pick < 85) op = REQ_TICK;
    else if (pick < 95) op = REQ_CLEAR;
    else                op = REQ_SPARE;
    if ($urandom_range(0, 9) == 0) delay = DELAY_W'($urandom);
    else                           delay = DELAY_W'($urandom_range(0, 3));
    offer(op, CODE_W'($urandom), delay, SENDER_W'($urandom), GROUP_W'($urandom),
          $urandom_range(0, 3) == 0);
  endtask

  // Stops offering and waits until every awaited result has arrived and the
  // block has had time to finish a tick that delivers nothing.
  task automatic settle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register; valid stays high so that writes can follow back to back.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic program_masks(input logic [MASK_W-1:0] registered,
                               input logic [MASK_W-1:0] muted,
                               input logic [MASK_W-1:0] handler);
    cfg_write(CFG_REGISTERED, registered);
    cfg_write(CFG_MUTED, muted);
    cfg_write(CFG_HANDLER, handler);
    cfg_bus.valid <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request, none at the end.
  initial begin
    int held;
    res_bus.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        res_bus.ready <= 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_off_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Request side and verdict.
  initial begin
    rst                    = 1'b1;
    drained                = 1'b0;
    hold_off_req           = 1'b0;
    quiet_tail             = 1'b0;
    req_bus.valid          = 1'b0;
    req_bus.req_type       = REQ_ADD;
    req_bus.signal_code    = '0;
    req_bus.delay_ticks    = '0;
    req_bus.sender_id      = '0;
    req_bus.receiver_group = '0;
    req_bus.broadcast      = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_REGISTERED;
    cfg_bus.data           = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part with every group able to receive.
    program_masks(8'hFF, 8'h00, 8'hFF);
    offer(REQ_ADD, 16'hFFFF, 16'd0, 8'hFF, 3'd7, 1'b0);
    offer(REQ_ADD, 16'h0000, 16'd0, 8'h00, 3'd0, 1'b0);
    offer(REQ_ADD, 16'h1234, 16'd1, 8'h5A, 3'd3, 1'b1);
    offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
    offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
    // A tick on an empty queue and the spare request code cause nothing.
    offer(REQ_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 3'd7, 1'b1);
    offer(REQ_SPARE, 16'hBEEF, 16'd0, 8'h11, 3'd2, 1'b1);
    // Clearing drops entries that were never delivered.
    offer(REQ_ADD, 16'hAAAA, 16'hFFFF, 8'h3C, 3'd1, 1'b0);
    offer(REQ_ADD, 16'h5555, 16'd0, 8'hC3, 3'd2, 1'b0);
    offer(REQ_CLEAR, '0, '0, '0, '0, 1'b0);
    offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
    // Full queue of broadcasts, one rejected add, then the widest tick.
    for (int k = 0; k < QUEUE_DEPTH; k++)
      offer(REQ_ADD, CODE_W'(16'h8000 + k), 16'd0, SENDER_W'(k), GROUP_W'(k), 1'b1);
    offer(REQ_ADD, 16'hDEAD, 16'd0, 8'h77, 3'd4, 1'b1);
    offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
    // Delivery on the third tick after the add.
    offer(REQ_ADD, 16'h0F0F, 16'd2, 8'h99, 3'd5, 1'b0);
    offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
    offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
    offer(REQ_TICK, '0, '0, '0, '0, 1'b0);

    // Random phases, each under its own set of masks.
    for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        1: begin
          cfg_write(CFG_SPARE, 8'hFF);
          program_masks(MASK_W'($urandom), MASK_W'($urandom), MASK_W'($urandom));
        end
        2: program_masks(8'h00, 8'h00, 8'h00);
        3: program_masks(8'hFF, 8'hFF, 8'hFF);
        4: program_masks(8'hFF, 8'h00, 8'hFF);
        5: program_masks(MASK_W'($urandom), 8'h00, MASK_W'($urandom));
        default: begin
          quiet_tail = 1'b1;
          program_masks(8'hFF, MASK_W'($urandom & $urandom), 8'hFF);
        end
      endcase

      // Results are held back while the queue fills, overflows and is ticked,
      // so that the block has to stall its request side.
      if (phase == 4) begin
        offer(REQ_CLEAR, '0, '0, '0, '0, 1'b0);
        hold_off_req = 1'b1;
        for (int k = 0; k < QUEUE_DEPTH + 2; k++)
          offer(REQ_ADD, CODE_W'($urandom), 16'd0, SENDER_W'($urandom),
                GROUP_W'($urandom), 1'b1);
        offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
        for (int k = 0; k < 4; k++)
          offer(REQ_ADD, CODE_W'($urandom), 16'd1, SENDER_W'($urandom),
                GROUP_W'(k), 1'b0);
        offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
        offer(REQ_TICK, '0, '0, '0, '0, 1'b0);
        settle();
      end

      repeat (PHASE_ITEMS) random_request();
    end

    // Drain, then check that nothing is left over.
    settle();
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("delayed_signal_dispatcher_core verification clean");
    end else begin
      $display("delayed_signal_dispatcher_core verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("delayed_signal_dispatcher_core verification failed");
    $finish;
  end

endmodule

/* sim.f */
sv/dsd_pkg.sv
sv/dsd_if.sv
sv/dsd_datapath.sv
sv/dsd_ctrl.sv
sv/delayed_signal_dispatcher_core.sv
tb/dispatch_checker.sv
tb/delayed_signal_dispatcher_core_tb.sv
